// ----- hw/rtl/dbadc_pkg.sv -----
package dbadc_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PLAY  = 2'd2,
    MODE_CAPT  = 2'd3
  } mode_e;

  localparam logic [7:0] OFF_STATUS   = 8'h00;
  localparam logic [7:0] OFF_ENABLE   = 8'h04;
  localparam logic [7:0] OFF_P0_LO    = 8'h08;
  localparam logic [7:0] OFF_P1_LO    = 8'h0C;
  localparam logic [7:0] OFF_P0_LEN   = 8'h10;
  localparam logic [7:0] OFF_P1_LEN   = 8'h14;
  localparam logic [7:0] OFF_IN_SUP   = 8'h18;
  localparam logic [7:0] OFF_C_LO     = 8'h1C;
  localparam logic [7:0] OFF_C_LEN    = 8'h20;
  localparam logic [7:0] OFF_C_REQ    = 8'h24;
  localparam logic [7:0] OFF_P0_HI    = 8'h28;
  localparam logic [7:0] OFF_P1_HI    = 8'h30;
  localparam logic [7:0] OFF_C_HI     = 8'h34;

  localparam logic [1:0] NO_BUFFER = 2'd3;
  localparam logic [2:0] ST_PLAY1  = 3'b001;
  localparam logic [2:0] ST_PLAY2  = 3'b010;
  localparam logic [2:0] ST_CAPT   = 3'b100;

  localparam logic [1:0] SRC_CAPT = 2'd2;

  localparam logic CFG_IN_SUP  = 1'b0;
  localparam logic CFG_OUT_PRS = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        xfer_valid;
    logic [1:0]  xfer_source;
    logic [63:0] xfer_address;
    logic [31:0] xfer_bytes;
    logic        play_active;
    logic        last;
  } out_item_t;

endpackage

// ----- hw/rtl/dbadc_if.sv -----
interface dbadc_in_if;
  import dbadc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbadc_out_if;
  import dbadc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/double_buffer_audio_dma_controller.sv -----
// Control part of a ping-pong audio playback and capture device.
// Channel in_if carries items: register reads, register writes, playback
// demand events and capture events. Channel out_if returns one result per
// item, or two when a playback demand draws from both buffers; the last flag
// marks the final result of an item. Both use valid/ready, an item moves at
// a clock edge where both are high.
// Input_supported (index 0) and output_present (index 1) must be written on the
// configuration port only while the block is idle; the block does not enforce it.
// An accepted item is executed in the same cycle and its results land in a
// four-entry result queue, visible from the next cycle. An item is accepted
// whenever the queue has room for two more results, so the block takes one
// item per cycle while the receiver keeps up; the queue drains one result
// per cycle while the receiver is ready, which limits the sustained rate for
// a demand that yields two transfers.
// When the receiver stalls, the queue fills and ready drops until space frees.
// Reset empties the queue and returns all state to its reset values, with no
// playback buffer current and both configuration bits set.
module double_buffer_audio_dma_controller import dbadc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [0:0]  cfg_data_i,
  dbadc_in_if.sink    in_if,
  dbadc_out_if.source out_if
);

  out_item_t r0, r1;
  logic      two, room, go, cwe;

  assign in_if.ready = room;
  assign go  = in_if.valid && room;
  // Writes beyond the two registers are dropped.
  assign cwe = cfg_we_i && (cfg_idx_i[1] == 1'b0);

  dbadc_core u_core (
    .clk_i, .rst_ni,
    .cfg_we_i(cwe), .cfg_idx_i(cfg_idx_i[0]), .cfg_data_i(cfg_data_i[0]),
    .go_i(go), .item_i(in_if.data),
    .res0_o(r0), .res1_o(r1), .two_o(two)
  );

  dbadc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(go), .two_i(two), .d0_i(r0), .d1_i(r1),
    .room_o(room), .out_o(out_if)
  );

endmodule

// ----- hw/rtl/dbadc_core.sv -----
// Executes one item per cycle, while go_i is high, against the register state
// and produces one or two result entries, pushed into the result queue.
module dbadc_core import dbadc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_data_i,
  input  logic      go_i,
  input  in_item_t  item_i,
  output out_item_t res0_o,
  output out_item_t res1_o,
  output logic      two_o
);

  logic        in_sup_q, out_prs_q;
  logic [2:0]  status_q, status_d, enable_q, enable_d;
  logic        irq_q, irq_d, playing_q, playing_d, cact_q, cact_d;
  logic [1:0]  cur_q, cur_d;
  logic [63:0] pbase_q [2];
  logic [63:0] pbase_d [2];
  logic [31:0] plen_q [2];
  logic [31:0] plen_d [2];
  logic [31:0] poff_q [2];
  logic [31:0] poff_d [2];
  logic [63:0] cbase_q, cbase_d;
  logic [31:0] clen_q, clen_d, coff_q, coff_d, creq_q, creq_d;

  logic [31:0] rd;
  logic [31:0] free0, free1, w0, w1, missing, n, cnew;
  logic        bi, bj;
  logic [2:0]  nst;
  logic [1:0]  nx;
  logic [1:0]  src0, src1;
  logic [63:0] addr0, addr1;
  logic [31:0] byt0, byt1;

  always_comb begin
    status_d = status_q; enable_d = enable_q; irq_d = irq_q;
    playing_d = playing_q; cact_d = cact_q; cur_d = cur_q;
    pbase_d = pbase_q; plen_d = plen_q; poff_d = poff_q;
    cbase_d = cbase_q; clen_d = clen_q; coff_d = coff_q; creq_d = creq_q;
    rd = '0; nst = '0; nx = '0;
    src0 = '0; src1 = '0; addr0 = '0; addr1 = '0; byt0 = '0; byt1 = '0;
    bi = cur_q[0]; bj = ~cur_q[0];
    free0 = {16'd0, item_i.amount};
    w0 = (plen_q[bi] < free0) ? plen_q[bi] : free0;
    free1 = free0 - w0;
    w1 = (plen_q[bj] < free1) ? plen_q[bj] : free1;
    missing = clen_q - coff_q;
    n = ({16'd0, item_i.amount} < missing) ? {16'd0, item_i.amount} : missing;
    cnew = coff_q + n;
    unique case (mode_e'(item_i.mode))
      MODE_READ: begin
        unique case (item_i.reg_offset)
          OFF_STATUS: begin
            rd = {29'd0, status_q & enable_q};
            if ((status_q & enable_q) != 3'd0) irq_d = 1'b0;
          end
          OFF_IN_SUP: rd = {31'd0, in_sup_q};
          OFF_C_REQ:  rd = creq_q;
          default:    rd = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (item_i.reg_offset)
          OFF_ENABLE: begin
            if (out_prs_q) begin
              plen_d[0] = '0; poff_d[0] = '0; plen_d[1] = '0; poff_d[1] = '0;
            end
            if (in_sup_q) begin
              cact_d = item_i.write_data[2]; clen_d = '0; coff_d = '0;
            end
            cur_d = NO_BUFFER;
            enable_d = item_i.write_data[2:0];
            status_d = ST_PLAY1 | ST_PLAY2;
            irq_d = ((status_d & enable_d) != 3'd0);
          end
          OFF_P0_LO: pbase_d[0][31:0]  = item_i.write_data;
          OFF_P0_HI: pbase_d[0][63:32] = item_i.write_data;
          OFF_P1_LO: pbase_d[1][31:0]  = item_i.write_data;
          OFF_P1_HI: pbase_d[1][63:32] = item_i.write_data;
          OFF_P0_LEN, OFF_P1_LEN: begin
            if (item_i.reg_offset == OFF_P0_LEN) begin
              if (cur_q == NO_BUFFER) cur_d = 2'd0;
              plen_d[0] = item_i.write_data; poff_d[0] = '0;
              status_d = status_q & ~ST_PLAY1;
            end else begin
              if (cur_q == NO_BUFFER) cur_d = 2'd1;
              plen_d[1] = item_i.write_data; poff_d[1] = '0;
              status_d = status_q & ~ST_PLAY2;
            end
            if (out_prs_q) playing_d = 1'b1;
          end
          OFF_C_LO: cbase_d[31:0]  = item_i.write_data;
          OFF_C_HI: cbase_d[63:32] = item_i.write_data;
          OFF_C_LEN: begin
            clen_d = item_i.write_data; coff_d = '0; creq_d = item_i.write_data;
            status_d = status_q & ~ST_CAPT;
            irq_d = ((status_d & enable_q) != 3'd0);
          end
          default: ;
        endcase
      end
      MODE_PLAY: begin
        if (out_prs_q && playing_q) begin
          if (cur_q != NO_BUFFER) begin
            if (w0 != 32'd0) begin
              src0 = {1'b0, bi}; addr0 = pbase_q[bi] + {32'd0, poff_q[bi]};
              byt0 = w0; nx = 2'd1;
              poff_d[bi] = poff_q[bi] + w0; plen_d[bi] = plen_q[bi] - w0;
              if (plen_d[bi] == 32'd0) nst = nst | (bi ? ST_PLAY2 : ST_PLAY1);
            end
            if (w1 != 32'd0) begin
              if (nx == 2'd0) begin
                src0 = {1'b0, bj}; addr0 = pbase_q[bj] + {32'd0, poff_q[bj]};
                byt0 = w1;
              end else begin
                src1 = {1'b0, bj}; addr1 = pbase_q[bj] + {32'd0, poff_q[bj]};
                byt1 = w1;
              end
              nx = nx + 2'd1;
              poff_d[bj] = poff_q[bj] + w1; plen_d[bj] = plen_q[bj] - w1;
              if (plen_d[bj] == 32'd0) nst = nst | (bj ? ST_PLAY2 : ST_PLAY1);
            end
            if (plen_d[bi] == 32'd0)
              cur_d = (plen_d[bj] != 32'd0) ? {1'b0, bj} : NO_BUFFER;
            if (free1 != w1) playing_d = 1'b0;
          end else if (free0 != 32'd0) begin
            playing_d = 1'b0;
          end
          if (nst != 3'd0 && nst != status_q) begin
            status_d = status_q | nst;
            irq_d = ((status_d & enable_q) != 3'd0);
          end
        end
      end
      MODE_CAPT: begin
        if (in_sup_q && cact_q && missing != 32'd0 && n != 32'd0) begin
          src0 = SRC_CAPT; addr0 = cbase_q + {32'd0, coff_q}; byt0 = n; nx = 2'd1;
          coff_d = cnew;
          if (clen_q == cnew && status_q != ST_CAPT) begin
            status_d = status_q | ST_CAPT;
            irq_d = ((status_d & enable_q) != 3'd0);
          end
        end
      end
      default: ;
    endcase
  end

  assign two_o = (nx == 2'd2);
  always_comb begin
    res0_o.read_data = rd;          res1_o.read_data = rd;
    res0_o.irq_level = irq_d;       res1_o.irq_level = irq_d;
    res0_o.play_active = playing_d; res1_o.play_active = playing_d;
    res0_o.xfer_valid = (nx != 2'd0); res1_o.xfer_valid = 1'b1;
    res0_o.xfer_source = src0;      res1_o.xfer_source = src1;
    res0_o.xfer_address = addr0;    res1_o.xfer_address = addr1;
    res0_o.xfer_bytes = byt0;       res1_o.xfer_bytes = byt1;
    res0_o.last = (nx != 2'd2);     res1_o.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sup_q <= 1'b1; out_prs_q <= 1'b1;
      status_q <= '0; enable_q <= '0; irq_q <= 1'b0; playing_q <= 1'b0;
      cact_q <= 1'b0; cur_q <= NO_BUFFER;
      pbase_q[0] <= '0; pbase_q[1] <= '0; plen_q[0] <= '0; plen_q[1] <= '0;
      poff_q[0] <= '0; poff_q[1] <= '0;
      cbase_q <= '0; clen_q <= '0; coff_q <= '0; creq_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IN_SUP) in_sup_q <= cfg_data_i;
        else out_prs_q <= cfg_data_i;
      end
      if (go_i) begin
        status_q <= status_d; enable_q <= enable_d; irq_q <= irq_d;
        playing_q <= playing_d; cact_q <= cact_d; cur_q <= cur_d;
        pbase_q <= pbase_d; plen_q <= plen_d; poff_q <= poff_d;
        cbase_q <= cbase_d; clen_q <= clen_d; coff_q <= coff_d; creq_q <= creq_d;
      end
    end
  end

endmodule

// ----- hw/rtl/dbadc_queue.sv -----
// Result queue of four entries; accepts up to two pushes per cycle.
module dbadc_queue import dbadc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      two_i,
  input  out_item_t d0_i,
  input  out_item_t d1_i,
  output logic      room_o,
  dbadc_out_if.source out_o
);

  out_item_t   mem_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [2:0]  nadd;

  assign out_o.valid = (cnt_q != 3'd0);
  assign out_o.data  = mem_q[rp_q];
  assign pop   = out_o.valid && out_o.ready;
  assign room_o = (cnt_q <= 3'd2);
  assign nadd  = push_i ? (two_i ? 3'd2 : 3'd1) : 3'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= d0_i;
      if (two_i) mem_q[wp_q + 2'd1] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + nadd[1:0];
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_q + nadd - {2'd0, pop};
    end
  end

endmodule

// ----- verif/dbadc_scoreboard.sv -----
`timescale 1ns / 100ps

module dbadc_scoreboard import dbadc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          xfers_o
);

  // Shadow copy of the controller state.
  logic        in_sup, out_prs;
  logic [2:0]  status, enables;
  logic        irq, playing, capt_on;
  logic [1:0]  cur_buf;
  logic [63:0] pbase [2];
  logic [31:0] plen [2];
  logic [31:0] poff [2];
  logic [63:0] cbase;
  logic [31:0] clen, coff, creq;

  out_item_t   expected_q [$];
  out_item_t   xfers [2];
  int          nx;

  function automatic void shadow_reset();
    in_sup = 1'b1; out_prs = 1'b1;
    status = '0; enables = '0; irq = 1'b0; playing = 1'b0; capt_on = 1'b0;
    cur_buf = NO_BUFFER;
    pbase[0] = '0; pbase[1] = '0; plen[0] = '0; plen[1] = '0;
    poff[0] = '0; poff[1] = '0;
    cbase = '0; clen = '0; coff = '0; creq = '0;
  endfunction

  function automatic void note_xfer(logic [1:0] src, logic [63:0] addr, logic [31:0] n);
    out_item_t t;
    t = '0;
    t.xfer_valid = 1'b1; t.xfer_source = src; t.xfer_address = addr; t.xfer_bytes = n;
    if (nx < 2) xfers[nx] = t;
    nx++;
  endfunction

  // A status update equal to the present status is dropped entirely.
  function automatic void raise_status(logic [2:0] s);
    if (s != 0 && s != status) begin
      status = status | s;
      irq = (status & enables) != 0;
    end
  endfunction

  function automatic void drain_buffer(int b, ref logic [31:0] free_b, ref logic [2:0] ns);
    logic [31:0] w;
    w = (plen[b] < free_b) ? plen[b] : free_b;
    if (w != 0) begin
      note_xfer(b[1:0], pbase[b] + {32'd0, poff[b]}, w);
      poff[b] += w;
      plen[b] -= w;
      free_b -= w;
      if (plen[b] == 0) ns |= (b != 0) ? ST_PLAY2 : ST_PLAY1;
    end
  endfunction

  function automatic void start_buffer(int b, logic [31:0] len);
    if (cur_buf == NO_BUFFER) cur_buf = b[1:0];
    plen[b] = len;
    poff[b] = '0;
    if (out_prs) playing = 1'b1;
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [31:0] rd, free_b, missing, n;
    logic [2:0]  ns;
    int          i, j, cnt;
    out_item_t   r;
    rd = '0; nx = 0; ns = '0;
    case (mode_e'(it.mode))
      MODE_READ: begin
        case (it.reg_offset)
          OFF_STATUS: begin
            rd = {29'd0, status & enables};
            if (rd != 0) irq = 1'b0;
          end
          OFF_IN_SUP: rd = {31'd0, in_sup};
          OFF_C_REQ:  rd = creq;
          default:    rd = '0;
        endcase
      end
      MODE_WRITE: begin
        case (it.reg_offset)
          OFF_ENABLE: begin
            if (out_prs) begin
              plen[0] = '0; poff[0] = '0; plen[1] = '0; poff[1] = '0;
            end
            if (in_sup) begin
              capt_on = it.write_data[2];
              clen = '0; coff = '0;
            end
            cur_buf = NO_BUFFER;
            enables = it.write_data[2:0];
            status = ST_PLAY1 | ST_PLAY2;
            irq = (status & enables) != 0;
          end
          OFF_P0_LO: pbase[0][31:0] = it.write_data;
          OFF_P0_HI: pbase[0][63:32] = it.write_data;
          OFF_P1_LO: pbase[1][31:0] = it.write_data;
          OFF_P1_HI: pbase[1][63:32] = it.write_data;
          OFF_P0_LEN: begin
            start_buffer(0, it.write_data);
            status &= ~ST_PLAY1;
          end
          OFF_P1_LEN: begin
            start_buffer(1, it.write_data);
            status &= ~ST_PLAY2;
          end
          OFF_C_LO: cbase[31:0] = it.write_data;
          OFF_C_HI: cbase[63:32] = it.write_data;
          OFF_C_LEN: begin
            clen = it.write_data; coff = '0; creq = it.write_data;
            status &= ~ST_CAPT;
            irq = (status & enables) != 0;
          end
          default: ;
        endcase
      end
      MODE_PLAY: begin
        free_b = {16'd0, it.amount};
        if (out_prs && playing) begin
          if (cur_buf != NO_BUFFER) begin
            i = cur_buf; j = i ^ 1;
            drain_buffer(i, free_b, ns);
            drain_buffer(j, free_b, ns);
            if (plen[i] == 0) cur_buf = (plen[j] != 0) ? j[1:0] : NO_BUFFER;
          end
          if (free_b != 0) playing = 1'b0;
          raise_status(ns);
        end
      end
      default: begin
        if (in_sup && capt_on) begin
          missing = clen - coff;
          n = ({16'd0, it.amount} < missing) ? {16'd0, it.amount} : missing;
          if (missing != 0 && n != 0) begin
            note_xfer(SRC_CAPT, cbase + {32'd0, coff}, n);
            coff += n;
            if (clen == coff) raise_status(ST_CAPT);
          end
        end
      end
    endcase
    cnt = (nx == 0) ? 1 : nx;
    for (int k = 0; k < cnt; k++) begin
      r = (k < nx) ? xfers[k] : '0;
      r.read_data = rd;
      r.irq_level = irq;
      r.play_active = playing;
      r.last = (k == cnt - 1);
      expected_q.push_back(r);
    end
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  initial begin
    errors_o = 0;
    results_o = 0;
    xfers_o = 0;
    shadow_reset();
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      shadow_reset();
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == {1'b0, CFG_IN_SUP}) in_sup = cfg_data_i[0];
        else if (cfg_idx_i == {1'b0, CFG_OUT_PRS}) out_prs = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (out_data_i.xfer_valid) xfers_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: %p", out_data_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("read_data", e.read_data, out_data_i.read_data);
          compare_field("irq_level", e.irq_level, out_data_i.irq_level);
          compare_field("xfer_valid", e.xfer_valid, out_data_i.xfer_valid);
          compare_field("xfer_source", e.xfer_source, out_data_i.xfer_source);
          compare_field("xfer_address", e.xfer_address, out_data_i.xfer_address);
          compare_field("xfer_bytes", e.xfer_bytes, out_data_i.xfer_bytes);
          compare_field("play_active", e.play_active, out_data_i.play_active);
          compare_field("last", e.last, out_data_i.last);
        end
      end
    end
  end

endmodule

// ----- verif/double_buffer_audio_dma_controller_test.sv -----
`timescale 1ns / 100ps

module double_buffer_audio_dma_controller_test;
  import dbadc_pkg::*;

  // Wait limit in cycles without any accepted item or result.
  localparam int StallLimit = 5000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [0:0] cfg_data;

  dbadc_in_if  in_ch ();
  dbadc_out_if out_ch ();

  int errors, pending, results, xfers;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int quiet_cycles;
  int items_sent;

  double_buffer_audio_dma_controller u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source)
  );

  // The checker sees both channels and the configuration port, and keeps
  // its own copy of the controller state to predict every result.
  dbadc_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .xfers_o     (xfers)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn at every falling edge, unless a long
  // hold-off is in progress, in which case it stays low.
  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // across back-to-back items; the sender idles only at random, and valid
  // is dropped when the sender goes quiet before a configuration change.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic reg_write(logic [7:0] off, logic [31:0] val);
    in_item_t it;
    it = '0;
    it.mode = MODE_WRITE; it.reg_offset = off; it.write_data = val;
    it.amount = $urandom;
    send_item(it);
  endtask

  task automatic reg_read(logic [7:0] off);
    in_item_t it;
    it = '0;
    it.mode = MODE_READ; it.reg_offset = off; it.write_data = $urandom;
    it.amount = $urandom;
    send_item(it);
  endtask

  task automatic audio_event(mode_e m, logic [15:0] amt);
    in_item_t it;
    it.mode = m; it.reg_offset = $urandom; it.write_data = $urandom; it.amount = amt;
    send_item(it);
  endtask

  // Stop offering, drain all results, then let the block settle before
  // touching config.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(logic [1:0] idx, logic val);
    wait_idle();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Small lengths keep buffers emptying often so that status, irq and the
  // buffer swap are exercised; a few writes use the full 32-bit range.
  function automatic logic [31:0] pick_length();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'd0;
      default: return $urandom_range(600);
    endcase
  endfunction

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(9))
      0:       return 16'hFFFF;
      1:       return 16'd0;
      2:       return $urandom;
      default: return $urandom_range(300);
    endcase
  endfunction

  // One well-formed session: program bases, enable, queue buffers, then a run of
  // demand and capture events with status reads, buffer refills and random register accesses.
  task automatic play_session();
    logic [7:0] offs [13];
    offs = '{OFF_STATUS, OFF_ENABLE, OFF_P0_LO, OFF_P1_LO, OFF_P0_LEN, OFF_P1_LEN,
             OFF_IN_SUP, OFF_C_LO, OFF_C_LEN, OFF_C_REQ, OFF_P0_HI, OFF_P1_HI,
             OFF_C_HI};
    reg_write(OFF_P0_LO, $urandom); reg_write(OFF_P0_HI, $urandom);
    reg_write(OFF_P1_LO, $urandom); reg_write(OFF_P1_HI, $urandom);
    reg_write(OFF_C_LO, $urandom);  reg_write(OFF_C_HI, $urandom);
    reg_write(OFF_ENABLE, $urandom);
    reg_write(OFF_P0_LEN, pick_length());
    reg_write(OFF_P1_LEN, pick_length());
    reg_write(OFF_C_LEN, pick_length());
    repeat ($urandom_range(10, 30)) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: audio_event(MODE_PLAY, pick_amount());
        6, 7, 8, 9:       audio_event(MODE_CAPT, pick_amount());
        10, 11:           reg_read(OFF_STATUS);
        12:               reg_write(OFF_P0_LEN, pick_length());
        13:               reg_write(OFF_P1_LEN, pick_length());
        14:               reg_write(OFF_C_LEN, pick_length());
        15:               reg_read(offs[$urandom_range(12)]);
        16:               reg_write(offs[$urandom_range(12)], $urandom);
        17:               reg_read($urandom);
        default:          reg_write($urandom, $urandom);
      endcase
    end
  endtask

  task automatic random_phase(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) audio_event(mode_e'($urandom_range(2, 3)), $urandom);
          else reg_read($urandom);
        end
      end else begin
        play_session();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: events while idle, reads of every readable register and an
    // unknown one, then a session with both buffers drawn from in one demand,
    // unmet demand, a full capture buffer and repeated status.
    audio_event(MODE_PLAY, 16'd100);
    audio_event(MODE_CAPT, 16'd100);
    reg_read(OFF_IN_SUP);
    reg_read(8'hFF);
    reg_write(OFF_P0_LO, 32'hFFFF_FFF0); reg_write(OFF_P0_HI, 32'hFFFF_FFFF);
    reg_write(OFF_P1_LO, 32'h1000);      reg_write(OFF_P1_HI, 32'h0);
    reg_write(OFF_C_LO, 32'h2000);       reg_write(OFF_C_HI, 32'h1);
    reg_write(OFF_ENABLE, 32'hFFFF_FFFF);
    reg_read(OFF_STATUS);
    reg_write(OFF_P0_LEN, 32'd40);
    reg_write(OFF_P1_LEN, 32'd60);
    reg_write(OFF_C_LEN, 32'd50);
    audio_event(MODE_PLAY, 16'd70);
    audio_event(MODE_PLAY, 16'hFFFF);
    audio_event(MODE_PLAY, 16'd5);
    audio_event(MODE_CAPT, 16'd0);
    audio_event(MODE_CAPT, 16'hFFFF);
    audio_event(MODE_CAPT, 16'd10);
    reg_read(OFF_C_REQ);
    reg_read(OFF_STATUS);
    reg_write(OFF_P0_LEN, 32'hFFFF_FFFF);
    audio_event(MODE_PLAY, 16'hFFFF);
    reg_write(8'hFF, 32'hFFFF_FFFF);

    // Hold the receiver off while the sender keeps going, so the result
    // queue fills and the block drops its ready.
    send_idle_pct = 32; recv_idle_pct = 69;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40);
    join
    random_phase(500);

    // Flip the configuration across all four settings between phases.
    write_config({1'b0, CFG_IN_SUP}, 1'b0);
    send_idle_pct = 69; recv_idle_pct = 32;
    random_phase(400);
    write_config({1'b0, CFG_OUT_PRS}, 1'b0);
    random_phase(250);
    write_config({1'b0, CFG_IN_SUP}, 1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(250);
    write_config({1'b0, CFG_OUT_PRS}, 1'b1);
    random_phase(450);

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d items and %0d results, %0d of them transfers,",
             items_sent, results, xfers);
    $display("over all four configuration settings and three idling profiles.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
